### sv/bmpd_pkg.sv
// Shared types, codes and constants of the 1-bit BMP stream decoder.
package bmpd_pkg;

	localparam int unsigned MAX_DIMENSION_DEFAULT = 65535;

	localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
	localparam logic [31:0] INFO_SIZE_MIN = 32'd40;
	localparam logic [31:0] HEADER_LAST_POS = 32'd53;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_OK    = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [3:0] ERR_SIGNATURE    = 4'd0;
	localparam logic [3:0] ERR_INFO_SIZE    = 4'd1;
	localparam logic [3:0] ERR_WIDTH        = 4'd2;
	localparam logic [3:0] ERR_HEIGHT       = 4'd3;
	localparam logic [3:0] ERR_PLANES       = 4'd4;
	localparam logic [3:0] ERR_BPP          = 4'd5;
	localparam logic [3:0] ERR_COMPRESSED   = 4'd6;
	localparam logic [3:0] ERR_TOO_LARGE    = 4'd7;
	localparam logic [3:0] ERR_OVERLAP      = 4'd8;
	localparam logic [3:0] ERR_TRUNCATED    = 4'd9;
	localparam logic [3:0] ERR_SHORT_HEADER = 4'd10;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_BADSIG  = 6'b000010,
		PH_SKIP    = 6'b000100,
		PH_PIXELS  = 6'b001000,
		PH_TRAILER = 6'b010000,
		PH_ERROR   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic        dark;
		logic [3:0]  error_code;
		logic        last_of_run;
	} result_t;

	// everything one byte fans out into: up to eight pixels, then an optional status
	typedef struct packed {
		logic [7:0]  pix_bits;
		logic [15:0] x_base;
		logic [15:0] y;
		logic [3:0]  pix_count;
		logic        status;
		logic [1:0]  kind;
		logic [3:0]  err;
	} burst_t;

endpackage

### sv/bmpd_parse.sv
// Header capture, validation, palette polarity and pixel addressing, one byte per request.
module bmpd_parse #(
	parameter int unsigned MAX_DIMENSION = bmpd_pkg::MAX_DIMENSION_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  bmpd_pkg::item_t  item,
	output logic             burst_valid,
	output bmpd_pkg::burst_t burst
);
	import bmpd_pkg::*;

	localparam logic [31:0] MaxDim = 32'(MAX_DIMENSION);

	function automatic logic [31:0] put_le(logic [31:0] v, logic [1:0] lane, logic [7:0] b);
		logic [31:0] r;
		r = v;
		r[{lane, 3'b000} +: 8] = b;
		return r;
	endfunction

	// floor(v/3) for v < 1024 by reciprocal multiply
	function automatic logic [8:0] div3(logic [9:0] v);
		logic [20:0] prod;
		prod = 21'(v) * 21'd683;
		return prod[19:11];
	endfunction

	logic [31:0] pos_q, pos_d;
	phase_t      phase_q, phase_d;
	logic [31:0] data_offset_q, data_offset_d;
	logic [31:0] info_size_q, info_size_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [31:0] plane_depth_q, plane_depth_d;
	logic [31:0] compression_q, compression_d;
	logic [9:0]  sum0_q, sum0_d, sum1_q, sum1_d;
	logic        one_dark_q, one_dark_d;
	logic [15:0] file_row_q, file_row_d;
	logic [12:0] row_byte_q, row_byte_d;
	logic [3:0]  saved_err_q, saved_err_d;
	logic [15:0] rows_q;
	logic        top_down_q;
	logic [13:0] padded_q;

	logic [7:0]  b;
	logic [1:0]  lane;
	logic [32:0] pal_base, pal_end, rel;
	logic [31:0] rows_abs;
	logic        chk_fail;
	logic [3:0]  chk_code;
	logic        capture_dims;
	logic [16:0] rb_sum;
	logic [14:0] rbp;
	logic [13:0] padded_new;
	logic [15:0] x_base, y;
	logic [16:0] diff;
	logic [3:0]  count;
	logic [13:0] rb_next;
	logic [15:0] row_inc;

	assign b = item.byte_value;
	assign lane = pos_q[1:0] - 2'd2;
	assign rows_abs = height_q[31] ? (32'd0 - height_q) : height_q;
	assign pal_base = 33'd14 + {1'b0, info_size_q};
	assign pal_end = pal_base + 33'd8;
	assign rel = {1'b0, pos_q} - pal_base;
	assign rb_sum = {1'b0, width_q[15:0]} + 17'd7;
	assign rbp = {1'b0, rb_sum[16:3]} + 15'd3;
	assign padded_new = {rbp[13:2], 2'b00};
	assign x_base = {row_byte_q, 3'b000};
	assign y = top_down_q ? file_row_q : (rows_q - 16'd1 - file_row_q);
	assign diff = {1'b0, width_q[15:0]} - {1'b0, x_base};
	assign rb_next = {1'b0, row_byte_q} + 14'd1;
	assign row_inc = file_row_q + 16'd1;

	always_comb begin
		chk_fail = 1'b1;
		priority if (phase_q == PH_BADSIG) chk_code = ERR_SIGNATURE;
		else if (info_size_q < INFO_SIZE_MIN) chk_code = ERR_INFO_SIZE;
		else if (width_q == 32'd0 || width_q[31]) chk_code = ERR_WIDTH;
		else if (height_q == 32'd0) chk_code = ERR_HEIGHT;
		else if (plane_depth_q[15:0] != 16'd1) chk_code = ERR_PLANES;
		else if (plane_depth_q[31:16] != 16'd1) chk_code = ERR_BPP;
		else if (compression_q != 32'd0) chk_code = ERR_COMPRESSED;
		else if (width_q > MaxDim || rows_abs > MaxDim) chk_code = ERR_TOO_LARGE;
		else if ({1'b0, data_offset_q} < pal_end) chk_code = ERR_OVERLAP;
		else begin
			chk_fail = 1'b0;
			chk_code = ERR_SIGNATURE;
		end
	end

	always_comb begin
		if (diff[16] || diff == 17'd0) count = 4'd0;
		else if (diff >= 17'd8) count = 4'd8;
		else count = diff[3:0];
	end

	always_comb begin
		pos_d = pos_q;
		phase_d = phase_q;
		data_offset_d = data_offset_q;
		info_size_d = info_size_q;
		width_d = width_q;
		height_d = height_q;
		plane_depth_d = plane_depth_q;
		compression_d = compression_q;
		sum0_d = sum0_q;
		sum1_d = sum1_q;
		one_dark_d = one_dark_q;
		file_row_d = file_row_q;
		row_byte_d = row_byte_q;
		saved_err_d = saved_err_q;
		capture_dims = 1'b0;
		burst = '0;

		if (phase_q == PH_HEADER || phase_q == PH_BADSIG) begin
			priority if (pos_q == 32'd0) data_offset_d = {24'd0, b};
			else if (pos_q == 32'd1 && phase_q == PH_HEADER
					&& {b, data_offset_q[7:0]} != BMP_SIGNATURE) phase_d = PH_BADSIG;
			else if (pos_q >= 32'd10 && pos_q < 32'd14)
				data_offset_d = put_le(data_offset_q, lane, b);
			else if (pos_q >= 32'd14 && pos_q < 32'd18)
				info_size_d = put_le(info_size_q, lane, b);
			else if (pos_q >= 32'd18 && pos_q < 32'd22) width_d = put_le(width_q, lane, b);
			else if (pos_q >= 32'd22 && pos_q < 32'd26) height_d = put_le(height_q, lane, b);
			else if (pos_q >= 32'd26 && pos_q < 32'd30)
				plane_depth_d = put_le(plane_depth_q, lane, b);
			else if (pos_q >= 32'd30 && pos_q < 32'd34)
				compression_d = put_le(compression_q, lane, b);
			else begin
			end
			if (pos_q == HEADER_LAST_POS) begin
				if (chk_fail) begin
					saved_err_d = chk_code;
					phase_d = PH_ERROR;
				end else begin
					phase_d = PH_SKIP;
					capture_dims = 1'b1;
				end
			end
		end else if (phase_q == PH_SKIP) begin
			if (pos_q == data_offset_q) begin
				one_dark_d = div3(sum0_q) > div3(sum1_q);
				phase_d = PH_PIXELS;
			end else if (!rel[32]) begin
				if (rel < 33'd3) sum0_d = sum0_q + {2'd0, b};
				else if (rel >= 33'd4 && rel < 33'd7) sum1_d = sum1_q + {2'd0, b};
			end
		end

		burst.pix_bits = one_dark_d ? b : ~b;
		burst.x_base = x_base;
		burst.y = y;
		if (phase_d == PH_PIXELS) begin
			burst.pix_count = count;
			if (rb_next >= padded_q) begin
				row_byte_d = '0;
				file_row_d = row_inc;
				if (row_inc >= rows_q) phase_d = PH_TRAILER;
			end else begin
				row_byte_d = rb_next[12:0];
			end
		end

		if (item.last_byte) begin
			burst.status = 1'b1;
			unique case (phase_d)
				PH_ERROR: begin
					burst.kind = KIND_ERROR;
					burst.err = saved_err_d;
				end
				PH_TRAILER: burst.kind = KIND_OK;
				PH_HEADER, PH_BADSIG: begin
					burst.kind = KIND_ERROR;
					burst.err = ERR_SHORT_HEADER;
				end
				default: begin
					burst.kind = KIND_ERROR;
					burst.err = ERR_TRUNCATED;
				end
			endcase
			pos_d = '0;
			phase_d = PH_HEADER;
			data_offset_d = '0;
			info_size_d = '0;
			width_d = '0;
			height_d = '0;
			plane_depth_d = '0;
			compression_d = '0;
			sum0_d = '0;
			sum1_d = '0;
			one_dark_d = 1'b1;
			file_row_d = '0;
			row_byte_d = '0;
			saved_err_d = '0;
		end else if (pos_q != '1) begin
			pos_d = pos_q + 32'd1;
		end
	end

	assign burst_valid = accept && (burst.pix_count != 4'd0 || burst.status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_HEADER;
			data_offset_q <= '0;
			info_size_q <= '0;
			width_q <= '0;
			height_q <= '0;
			plane_depth_q <= '0;
			compression_q <= '0;
			sum0_q <= '0;
			sum1_q <= '0;
			one_dark_q <= 1'b1;
			file_row_q <= '0;
			row_byte_q <= '0;
			saved_err_q <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
			phase_q <= phase_d;
			data_offset_q <= data_offset_d;
			info_size_q <= info_size_d;
			width_q <= width_d;
			height_q <= height_d;
			plane_depth_q <= plane_depth_d;
			compression_q <= compression_d;
			sum0_q <= sum0_d;
			sum1_q <= sum1_d;
			one_dark_q <= one_dark_d;
			file_row_q <= file_row_d;
			row_byte_q <= row_byte_d;
			saved_err_q <= saved_err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && capture_dims) begin
			rows_q <= rows_abs[15:0];
			top_down_q <= height_q[31];
			padded_q <= padded_new;
		end
	end

endmodule

### sv/bmpd_emit.sv
// Burst register and serializer: one result per cycle into the output register while the output is not stalled.
module bmpd_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              burst_valid,
	input  bmpd_pkg::burst_t  burst,
	output logic              free,
	output logic              result_valid,
	input  logic              result_stall,
	output bmpd_pkg::result_t result
);
	import bmpd_pkg::*;

	burst_t  burst_s1;
	logic    burst_valid_s1;
	logic [3:0] idx_q;
	result_t result_s2;
	logic    result_valid_s2;

	logic [3:0] total;
	logic       at_end, out_free, step;
	result_t    elem;

	assign total = burst_s1.pix_count + {3'd0, burst_s1.status};
	assign at_end = (idx_q == total - 4'd1);
	assign out_free = !result_valid_s2 || !result_stall;
	assign step = burst_valid_s1 && out_free;
	assign free = !burst_valid_s1 || (out_free && at_end);

	always_comb begin
		elem = '0;
		elem.last_of_run = at_end;
		if (idx_q < burst_s1.pix_count) begin
			elem.kind = KIND_PIXEL;
			elem.pixel_x = burst_s1.x_base + {12'd0, idx_q};
			elem.pixel_y = burst_s1.y;
			elem.dark = burst_s1.pix_bits[3'd7 - idx_q[2:0]];
		end else begin
			elem.kind = burst_s1.kind;
			elem.error_code = burst_s1.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_s1 <= 1'b0;
			idx_q <= '0;
			result_valid_s2 <= 1'b0;
		end else begin
			if (free) begin
				burst_valid_s1 <= burst_valid;
				idx_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + 4'd1;
			end
			if (out_free) result_valid_s2 <= burst_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && burst_valid) burst_s1 <= burst;
		if (step) result_s2 <= elem;
	end

	assign result_valid = result_valid_s2;
	assign result = result_s2;

endmodule

### sv/mono_bmp_stream_decoder.sv
// Top level of the streaming 1-bit BMP decoder.
// Input channel item/item_valid/item_stall carries one file byte per request, with
// last_byte marking the end of the file. Output channel result/result_valid/result_stall
// carries pixel results (column, row with the top row 0, dark flag) and, after the final
// byte, one status result: decoded ok or an error code.
// A header, padding or skipped byte causes no result and is taken every cycle while the
// burst stage is empty. A pixel data byte fans out into up to eight results and a final
// byte adds a status; the serializer sends one result per cycle while the output is not
// stalled, so the byte after such a byte waits while its results are sent.
// The first result of a byte is held in the burst stage before it enters the output
// register. The next byte is taken in the cycle the last result of the current one moves
// to the output register, so the two sides overlap.
// A stalled result holds in the output register; the burst stage behind it fills and
// then item_stall rises until the output moves again.
// arst_n clears all state but the captured dimensions and data; the block then waits for
// byte 0 of a file. After the final byte the decoder re-arms for the next file by itself.
module mono_bmp_stream_decoder #(
	parameter int unsigned MAX_DIMENSION = bmpd_pkg::MAX_DIMENSION_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  bmpd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output bmpd_pkg::result_t result
);
	import bmpd_pkg::*;

	logic   accept;
	logic   free;
	logic   burst_valid;
	burst_t burst;

	assign item_stall = !free;
	assign accept = item_valid && free;

	bmpd_parse #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.burst_valid (burst_valid),
		.burst       (burst)
	);

	bmpd_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.burst_valid  (burst_valid),
		.burst        (burst),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
